[hdl/b64uu_pkg.sv]
// ----------------------------------------------------------------------------
// b64uu_pkg
// Types, character constants and the alphabet map shared by the line encoder.
// ----------------------------------------------------------------------------
package b64uu_pkg;

    // Configuration register indexes (byte address bit 2)
    localparam logic REG_UU_MODE  = 1'b0;
    localparam logic REG_NEWLINE  = 1'b1;

    // Fixed characters
    localparam logic [7:0] CHAR_PAD_B64 = 8'h3D; // '='
    localparam logic [7:0] CHAR_PAD_UU  = 8'h60; // '`'
    localparam logic [7:0] CHAR_NL      = 8'h0A; // '\n'
    localparam logic [7:0] CHAR_SPACE   = 8'h20; // ' ', uu length offset

    // Output slot positions inside one job
    localparam int unsigned POS_PRE = 0;
    localparam int unsigned POS_S0  = 1;
    localparam int unsigned POS_S1  = 2;
    localparam int unsigned POS_S2  = 3;
    localparam int unsigned POS_S3  = 4;
    localparam int unsigned POS_NL  = 5;
    localparam int unsigned NUM_POS = 6;

    // One queued job: all characters caused by one input item
    typedef struct packed {
        logic       uu;        // alphabet / pad select
        logic       pre_en;    // uu length prefix
        logic [7:0] pre_char;
        logic       grp_en;    // four symbol / pad characters
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] pad_cnt;   // trailing pads among the four
        logic       nl_en;     // newline
    } t_job;

    // Queue status toward the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // 6-bit value to ASCII in the selected alphabet
    function automatic logic [7:0] sym_char(input logic uu, input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (uu) begin
            c = (v == 6'd0) ? CHAR_PAD_UU : (w + CHAR_SPACE);
        end else if (v < 6'd26) begin
            c = w + 8'd65;
        end else if (v < 6'd52) begin
            c = w + 8'd71;          // 'a' - 26
        end else if (v < 6'd62) begin
            c = w - 8'd4;           // '0' - 52
        end else if (v == 6'd62) begin
            c = 8'h2B;              // '+'
        end else begin
            c = 8'h2F;              // '/'
        end
        return c;
    endfunction

endpackage

[hdl/b64uu_front.sv]
// ----------------------------------------------------------------------------
// b64uu_front
// Takes input bytes, groups them in threes and builds one job per item.
// ----------------------------------------------------------------------------
module b64uu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_uu_mode,
    input  logic             i_append_nl,
    input  logic             i_push,
    input  logic [7:0]       i_data_byte,
    input  logic             i_byte_present,
    input  logic             i_first_of_line,
    input  logic             i_last_of_line,
    input  logic [7:0]       i_line_length,
    input  logic             i_q_full,
    output logic             o_q_push,
    output b64uu_pkg::t_job  o_job
);

    logic [15:0] r_held_bytes, n_held_bytes;
    logic [1:0]  r_held_cnt,   n_held_cnt;

    logic            accept;
    logic [15:0]     hb0, hb1;
    logic [1:0]      cnt0, cnt1;
    b64uu_pkg::t_job job;

    assign accept = i_push & ~i_q_full;

    always_comb begin
        cnt0 = i_first_of_line ? 2'd0  : r_held_cnt;
        hb0  = i_first_of_line ? 16'd0 : r_held_bytes;
        cnt1 = cnt0;
        hb1  = hb0;

        job          = '0;
        job.uu       = i_uu_mode;
        job.pre_en   = i_first_of_line & i_uu_mode;
        job.pre_char = i_line_length + b64uu_pkg::CHAR_SPACE;

        if (i_byte_present) begin
            unique case (cnt0)
                2'd0: begin
                    hb1  = {i_data_byte, 8'd0};
                    cnt1 = 2'd1;
                end
                2'd1: begin
                    hb1  = {hb0[15:8], i_data_byte};
                    cnt1 = 2'd2;
                end
                default: begin
                    job.grp_en = 1'b1;
                    job.b0     = hb0[15:8];
                    job.b1     = hb0[7:0];
                    job.b2     = i_data_byte;
                    hb1        = 16'd0;
                    cnt1       = 2'd0;
                end
            endcase
        end

        n_held_bytes = hb1;
        n_held_cnt   = cnt1;

        if (i_last_of_line) begin
            // flush a partial group with padding
            if (cnt1 == 2'd2) begin
                job.grp_en  = 1'b1;
                job.b0      = hb1[15:8];
                job.b1      = hb1[7:0];
                job.b2      = 8'd0;
                job.pad_cnt = 2'd1;
            end else if (cnt1 == 2'd1) begin
                job.grp_en  = 1'b1;
                job.b0      = hb1[15:8];
                job.b1      = 8'd0;
                job.b2      = 8'd0;
                job.pad_cnt = 2'd2;
            end
            job.nl_en    = i_append_nl;
            n_held_bytes = 16'd0;
            n_held_cnt   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bytes <= 16'd0;
            r_held_cnt   <= 2'd0;
        end else if (accept) begin
            r_held_bytes <= n_held_bytes;
            r_held_cnt   <= n_held_cnt;
        end
    end

    // items that cause no character are dropped here
    assign o_q_push = accept & (job.pre_en | job.grp_en | job.nl_en);
    assign o_job    = job;

endmodule

[hdl/b64uu_queue.sv]
// ----------------------------------------------------------------------------
// b64uu_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module b64uu_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b64uu_pkg::t_job       i_job,
    input  logic                  i_pop,
    output b64uu_pkg::t_job       o_job,
    output b64uu_pkg::t_q_status  o_status
);

    b64uu_pkg::t_job r_mem [2];
    logic            r_wr_ptr, r_rd_ptr;
    logic [1:0]      r_count;

    logic do_push, do_pop;

    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign do_push        = i_push & ~o_status.full;
    assign do_pop         = i_pop & ~o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/b64uu_back.sv]
// ----------------------------------------------------------------------------
// b64uu_back
// Walks the queued job one character a cycle into the output register, while that register is free or popped.
// ----------------------------------------------------------------------------
module b64uu_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  b64uu_pkg::t_job       i_job,
    input  b64uu_pkg::t_q_status  i_q_status,
    output logic                  o_q_pop,
    input  logic                  i_out_pop,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_char,
    output logic                  o_last_char
);

    localparam int unsigned NP = b64uu_pkg::NUM_POS;

    logic [NP-1:0] r_done, n_done;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_last_char;

    logic [NP-1:0] mask, rem, sel;
    logic          load, is_last;
    logic [7:0]    ch, pad;
    logic [5:0]    s0, s1, s2, s3;

    assign s0  = i_job.b0[7:2];
    assign s1  = {i_job.b0[1:0], i_job.b1[7:4]};
    assign s2  = {i_job.b1[3:0], i_job.b2[7:6]};
    assign s3  = i_job.b2[5:0];
    assign pad = i_job.uu ? b64uu_pkg::CHAR_PAD_UU : b64uu_pkg::CHAR_PAD_B64;

    assign mask = {i_job.nl_en, {4{i_job.grp_en}}, i_job.pre_en};
    assign rem  = mask & ~r_done;
    assign sel  = rem & (~rem + NP'(1));
    assign is_last = ((rem & ~sel) == '0);

    assign load = ~i_q_status.empty & (~r_out_valid | i_out_pop);

    always_comb begin
        ch = b64uu_pkg::CHAR_NL;
        priority if (sel[b64uu_pkg::POS_PRE]) begin
            ch = i_job.pre_char;
        end else if (sel[b64uu_pkg::POS_S0]) begin
            ch = b64uu_pkg::sym_char(i_job.uu, s0);
        end else if (sel[b64uu_pkg::POS_S1]) begin
            ch = b64uu_pkg::sym_char(i_job.uu, s1);
        end else if (sel[b64uu_pkg::POS_S2]) begin
            ch = (i_job.pad_cnt == 2'd2) ? pad : b64uu_pkg::sym_char(i_job.uu, s2);
        end else if (sel[b64uu_pkg::POS_S3]) begin
            ch = (i_job.pad_cnt != 2'd0) ? pad : b64uu_pkg::sym_char(i_job.uu, s3);
        end else begin
            ch = b64uu_pkg::CHAR_NL;
        end
    end

    always_comb begin
        n_done = r_done;
        if (load) begin
            n_done = is_last ? '0 : (r_done | sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char  <= ch;
            r_last_char <= is_last;
        end
    end

    assign o_q_pop     = load & is_last;
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_last_char;

endmodule

[hdl/base64_uuencode_line_encoder_core.sv]
// ----------------------------------------------------------------------------
// base64_uuencode_line_encoder_core
// Line encoder for base64 or uuencode, one raw byte in per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive the byte and its line flags, raise
//   push; the transaction completes when push is high and full is low.
//   Output side is a queue read port: while empty is low, o_out_char and
//   o_last_char show the oldest character; pop takes it. o_last_char marks
//   the final character caused by one input transaction.
//   Registers (APB, byte addresses): 0x0 uu_mode, 0x4 append_newline.
//   Write them only while the encoder is drained.
// Throughput:
//   The front end takes one byte a cycle while full is low into a two-entry
//   job queue. The back end emits one character a cycle while the output is
//   free or popped; a transaction causes 0 to 6 characters (about 4/3 per
//   byte on average plus prefix and newline), so the output port sets the
//   sustained rate. Path: an accepted job is written into the queue, then its
//   first character is loaded into the output register once that is free.
// Reset: synchronous, clears held bytes, queue and output; uu_mode = 0,
//   append_newline = 1.
// Stall: with pop low the output register holds, the queue fills and full
//   rises after at most two more jobs; nothing is dropped.
// ----------------------------------------------------------------------------
module base64_uuencode_line_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_first_of_line,
    input  logic        i_last_of_line,
    input  logic [7:0]  i_line_length,
    // result channel
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_char,
    output logic        o_last_char
);

    // configuration registers
    logic r_uu_mode;
    logic r_append_nl;
    logic cfg_wr;

    // front -> queue -> back
    logic                  q_push, q_pop;
    b64uu_pkg::t_job       front_job, head_job;
    b64uu_pkg::t_q_status  q_status;
    logic                  out_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uu_mode   <= 1'b0;
            r_append_nl <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                b64uu_pkg::REG_UU_MODE: r_uu_mode   <= pwdata[0];
                b64uu_pkg::REG_NEWLINE: r_append_nl <= pwdata[0];
                default:                r_uu_mode   <= r_uu_mode;
            endcase
        end
    end

    // register readback; low address bits are ignored
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[2])
            b64uu_pkg::REG_UU_MODE: prdata = {31'd0, r_uu_mode};
            b64uu_pkg::REG_NEWLINE: prdata = {31'd0, r_append_nl};
            default:                prdata = 32'd0;
        endcase
    end

    // front end: grouping of bytes, one job per transaction
    b64uu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_uu_mode       (r_uu_mode),
        .i_append_nl     (r_append_nl),
        .i_push          (push),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_first_of_line (i_first_of_line),
        .i_last_of_line  (i_last_of_line),
        .i_line_length   (i_line_length),
        .i_q_full        (q_status.full),
        .o_q_push        (q_push),
        .o_job           (front_job)
    );

    // decoupling queue
    b64uu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (front_job),
        .i_pop    (q_pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // back end: character sequencer and output register
    b64uu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_status  (q_status),
        .o_q_pop     (q_pop),
        .i_out_pop   (pop),
        .o_out_valid (out_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

    assign full  = q_status.full;
    assign empty = ~out_valid;

`ifndef SYNTHESIS
    // after reset nothing is waiting and the input is open
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("encoder not clean after reset");

    // a full queue always has a job for the back end
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !q_status.empty)
        else $error("queue full and empty together");

    // retiring a job always loads its final character
    a_retire_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (out_valid && o_last_char))
        else $error("job retired without final character");
`endif

endmodule
